// ----- hw/rtl/rmde_pkg.sv -----
// ----------------------------------------------------------------------------
// rmde_pkg
// Shared types and constants for the RTT mean-deviation estimator.
// ----------------------------------------------------------------------------
package rmde_pkg;

    // Default datapath sizes
    localparam int TIME_BITS_DEF      = 40;
    localparam int GAIN_FRAC_BITS_DEF = 16;

    // Sample counter, fixed width
    localparam int                 COUNT_W   = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Shift path covers gains 1/2 .. 1/32
    localparam int SHIFT_W   = 3;
    localparam int MAX_SHIFT = 5;

    // Gain reset values as right shifts of 1.0 (0.125 and 0.25)
    localparam int RTT_GAIN_RESET_SHIFT = 3;
    localparam int VAR_GAIN_RESET_SHIFT = 2;

    // Estimate after reset, truncated to the time width where used
    localparam logic [63:0] INIT_EST_RESET = 64'd1000000000;

    // Config register indexes
    localparam int         CFG_IDX_W         = 2;
    localparam logic [1:0] CFG_RTT_GAIN      = 2'd0;
    localparam logic [1:0] CFG_VAR_GAIN      = 2'd1;
    localparam logic [1:0] CFG_INIT_ESTIMATE = 2'd2;

    // Request operation codes
    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // Classification handed from front to back
    typedef struct packed {
        logic               restart;
        logic               use_shift;
        logic [SHIFT_W-1:0] rtt_shift;
        logic [SHIFT_W-1:0] var_shift;
    } rmde_class_t;

endpackage

// ----- hw/rtl/rmde_front.sv -----
// ----------------------------------------------------------------------------
// rmde_front
// Accepts requests, decodes the op and picks shift or multiply update mode.
// ----------------------------------------------------------------------------
module rmde_front #(
    parameter int TIME_BITS      = rmde_pkg::TIME_BITS_DEF,
    parameter int GAIN_FRAC_BITS = rmde_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_op,
    input  logic [TIME_BITS-1:0]      s_sample,
    input  logic [GAIN_FRAC_BITS:0]   rtt_gain,
    input  logic [GAIN_FRAC_BITS:0]   var_gain,
    input  logic                      q_full,
    output logic                      q_push,
    output rmde_pkg::rmde_class_t     q_class,
    output logic [TIME_BITS-1:0]      q_sample
);
    import rmde_pkg::*;

    localparam int F = GAIN_FRAC_BITS;

    // 1..MAX_SHIFT when g is exactly 2^-k, else 0
    function automatic logic [SHIFT_W-1:0] shift_of(input logic [F:0] g);
        logic [SHIFT_W-1:0] k;
        k = '0;
        for (int i = 1; i <= MAX_SHIFT; i++) begin
            if (g == ((F+1)'(1) << (F - i))) begin
                k = SHIFT_W'(i);
            end
        end
        return k;
    endfunction

    logic [SHIFT_W-1:0] ka;
    logic [SHIFT_W-1:0] kb;
    logic               both_shift;

    assign ka         = shift_of(rtt_gain);
    assign kb         = shift_of(var_gain);
    assign both_shift = (ka != '0) && (kb != '0);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_class.restart   = (s_op == OP_RESTART);
        q_class.use_shift = both_shift;
        q_class.rtt_shift = both_shift ? ka : '0;
        q_class.var_shift = both_shift ? kb : '0;
    end

    assign q_sample = s_sample;

endmodule

// ----- hw/rtl/rmde_queue.sv -----
// ----------------------------------------------------------------------------
// rmde_queue
// Small FIFO between front and back, push and pop in the same cycle.
// ----------------------------------------------------------------------------
module rmde_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = rmde_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    output logic              pop_valid,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data
);
    import rmde_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !do_pop) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (do_pop && !push) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/rmde_back.sv -----
// ----------------------------------------------------------------------------
// rmde_back
// Holds estimator state and applies one update per popped request.
// ----------------------------------------------------------------------------
module rmde_back #(
    parameter int TIME_BITS      = rmde_pkg::TIME_BITS_DEF,
    parameter int GAIN_FRAC_BITS = rmde_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  rmde_pkg::rmde_class_t         q_class,
    input  logic [TIME_BITS-1:0]          q_sample,
    input  logic [GAIN_FRAC_BITS:0]       rtt_gain,
    input  logic [GAIN_FRAC_BITS:0]       var_gain,
    input  logic [TIME_BITS-1:0]          init_est,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [TIME_BITS-1:0]          m_estimate,
    output logic [TIME_BITS-1:0]          m_variation,
    output logic [rmde_pkg::COUNT_W-1:0]  m_sample_count
);
    import rmde_pkg::*;

    localparam int         W        = TIME_BITS;
    localparam int         F        = GAIN_FRAC_BITS;
    localparam int         PW       = W + F + 1;
    localparam logic [F:0] GAIN_ONE = (F+1)'(1) << F;

    // Move cur toward target; shift path floors the signed step,
    // multiply path truncates the magnitude toward zero.
    function automatic logic [W-1:0] step_toward(
        input logic [W-1:0]       cur,
        input logic [W-1:0]       target,
        input logic               use_shift,
        input logic [SHIFT_W-1:0] k,
        input logic [F:0]         g
    );
        logic           up;
        logic [W-1:0]   d;
        logic [PW-1:0]  prod;
        logic [W-1:0]   mul_step;
        logic [W-1:0]   sh_floor;
        logic           rem_nz;
        up       = (target >= cur);
        d        = up ? (target - cur) : (cur - target);
        prod     = PW'(d) * PW'(g);
        mul_step = prod[W+F-1:F];
        sh_floor = d >> k;
        rem_nz   = ((d & ~({W{1'b1}} << k)) != '0);
        if (up) begin
            return cur + (use_shift ? sh_floor : mul_step);
        end
        return cur - (use_shift ? (sh_floor + W'(rem_nz)) : mul_step);
    endfunction

    logic [W-1:0]       est_reg,  est_next;
    logic [W-1:0]       var_reg,  var_next;
    logic [COUNT_W-1:0] cnt_reg,  cnt_next;
    logic               valid_reg;
    logic [F:0]         ga;
    logic [F:0]         gb;
    logic [W-1:0]       absdiff;
    logic               pop;

    assign q_ready = !valid_reg || m_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        ga      = (rtt_gain > GAIN_ONE) ? GAIN_ONE : rtt_gain;
        gb      = (var_gain > GAIN_ONE) ? GAIN_ONE : var_gain;
        absdiff = (q_sample >= est_reg) ? (q_sample - est_reg) : (est_reg - q_sample);
        priority if (q_class.restart) begin
            est_next = init_est;
            var_next = '0;
            cnt_next = '0;
        end else if (cnt_reg == '0) begin
            // first sample after restart or reset
            est_next = q_sample;
            var_next = q_sample >> 1;
            cnt_next = COUNT_W'(1);
        end else begin
            est_next = step_toward(est_reg, q_sample, q_class.use_shift,
                                   q_class.rtt_shift, ga);
            var_next = step_toward(var_reg, absdiff, q_class.use_shift,
                                   q_class.var_shift, gb);
            cnt_next = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            est_reg   <= INIT_EST_RESET[W-1:0];
            var_reg   <= '0;
            cnt_reg   <= '0;
        end else if (pop) begin
            valid_reg <= 1'b1;
            est_reg   <= est_next;
            var_reg   <= var_next;
            cnt_reg   <= cnt_next;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // State registers double as the result register
    assign m_valid        = valid_reg;
    assign m_estimate     = est_reg;
    assign m_variation    = var_reg;
    assign m_sample_count = cnt_reg;

endmodule

// ----- hw/rtl/rtt_mean_deviation_estimator_unit.sv -----
// ----------------------------------------------------------------------------
// rtt_mean_deviation_estimator_unit
// Smoothed RTT and mean-deviation estimator (Jacobson/Karels style).
// ----------------------------------------------------------------------------
// Each request is either an RTT measurement (op=0) or a restart (op=1) and
// returns one result: the smoothed RTT, the RTT mean deviation and the
// saturating sample count after that request. Throughput is one request per
// clock while m_ready stays high. An accepted request is written into the
// queue and popped into the back unit's state registers once the result
// register is free; its result is then presented on the m_ side from those
// registers. The back unit computes the estimate and the deviation with two
// TIME_BITS x (GAIN_FRAC_BITS+1) multipliers. A two-deep queue between the
// front decoder and the back unit keeps s_ready high while a result waits;
// s_ready drops only after two requests pile up behind a stalled result.
// When both gains are exactly 1/2..1/32 the update uses floored arithmetic
// shifts, otherwise Q1.GAIN_FRAC_BITS multiplies truncated toward zero;
// gains above 1.0 act as 1.0. Configuration writes take effect at once and
// must be issued while the block is idle; a new initial_estimate is used
// from the next restart. No start-up clearing pass is needed.
// ----------------------------------------------------------------------------
module rtt_mean_deviation_estimator_unit #(
    parameter int   TIME_BITS      = rmde_pkg::TIME_BITS_DEF,
    parameter int   GAIN_FRAC_BITS = rmde_pkg::GAIN_FRAC_BITS_DEF,
    localparam int  CFG_W          = (TIME_BITS > GAIN_FRAC_BITS + 1) ?
                                     TIME_BITS : GAIN_FRAC_BITS + 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config write port
    input  logic                          cfg_wr_en,
    input  logic [rmde_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]              cfg_wdata,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [TIME_BITS-1:0]          s_sample,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [TIME_BITS-1:0]          m_estimate,
    output logic [TIME_BITS-1:0]          m_variation,
    output logic [rmde_pkg::COUNT_W-1:0]  m_sample_count
);
    import rmde_pkg::*;

    localparam int W       = TIME_BITS;
    localparam int F       = GAIN_FRAC_BITS;
    localparam int CLASS_W = $bits(rmde_class_t);
    localparam int Q_W     = CLASS_W + W;

    // ---- configuration registers ----
    logic [F:0]   rtt_gain_reg;
    logic [F:0]   var_gain_reg;
    logic [W-1:0] init_est_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rtt_gain_reg <= (F+1)'(1) << (F - RTT_GAIN_RESET_SHIFT);
            var_gain_reg <= (F+1)'(1) << (F - VAR_GAIN_RESET_SHIFT);
            init_est_reg <= INIT_EST_RESET[W-1:0];
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_RTT_GAIN:      rtt_gain_reg <= cfg_wdata[F:0];
                CFG_VAR_GAIN:      var_gain_reg <= cfg_wdata[F:0];
                CFG_INIT_ESTIMATE: init_est_reg <= cfg_wdata[W-1:0];
                default: begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

    // ---- front: accept and classify ----
    logic          q_full;
    logic          q_push;
    rmde_class_t   f_class;
    logic [W-1:0]  f_sample;

    rmde_front #(
        .TIME_BITS      (TIME_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_op     (s_op),
        .s_sample (s_sample),
        .rtt_gain (rtt_gain_reg),
        .var_gain (var_gain_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_class  (f_class),
        .q_sample (f_sample)
    );

    // ---- queue between front and back ----
    logic [Q_W-1:0] q_out;
    logic           q_valid;
    logic           q_ready;
    rmde_class_t    q_class;
    logic [W-1:0]   q_sample;

    rmde_queue #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({f_class, f_sample}),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_ready),
        .pop_data  (q_out)
    );

    assign q_class  = q_out[Q_W-1:W];
    assign q_sample = q_out[W-1:0];

    // ---- back: state update and result register ----
    rmde_back #(
        .TIME_BITS      (TIME_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_class        (q_class),
        .q_sample       (q_sample),
        .rtt_gain       (rtt_gain_reg),
        .var_gain       (var_gain_reg),
        .init_est       (init_est_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_estimate     (m_estimate),
        .m_variation    (m_variation),
        .m_sample_count (m_sample_count)
    );

    // ---- assertions ----
    logic q_pop;
    assign q_pop = q_valid && q_ready;

    // restart clears deviation and count in the next result
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && q_class.restart |=> m_valid && m_sample_count == '0 && m_variation == '0)
        else $error("restart did not clear state");

    // a measurement always leaves a nonzero count
    a_measure_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && !q_class.restart |=> m_valid && m_sample_count != '0)
        else $error("measurement left count at zero");

    // estimate moves up toward a sample at or above it without overshoot
    a_est_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && !q_class.restart && q_sample >= m_estimate |=>
            m_estimate >= $past(m_estimate) && m_estimate <= $past(q_sample))
        else $error("estimate left the old-estimate to sample range");

    // front must not push into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push && !s_ready)
        else $error("push while queue full");

endmodule
